FILE: rtl/hbs_pkg.sv
// Shared types and constants for the height map bilinear sampler.
// Holds the item and result beats, the register indexes and the control
// structs passed between the sampler's submodules. No dependencies.
`default_nettype none

package hbs_pkg;

    // Widths fixed by the item and register formats.
    localparam int HEIGHT_W   = 16;
    localparam int COORD_W    = 32;
    localparam int INDEX_W    = 8;
    localparam int INV_W      = 24;
    localparam int DIM_W      = 9;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Item function codes.
    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Reset values of the registers and running extremes.
    localparam logic [INV_W-1:0]           INV_RESET    = 24'd65536;
    localparam logic signed [HEIGHT_W-1:0] LOWEST_INIT  = 16'sh7FFF;
    localparam logic signed [HEIGHT_W-1:0] HIGHEST_INIT = 16'sh8000;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Z   = 3'd1,
        CFG_INV_CELL   = 3'd2,
        CFG_GRID_WIDTH = 3'd3,
        CFG_GRID_DEPTH = 3'd4
    } cfg_reg_t;

    // One input beat.
    typedef struct packed {
        logic                         func;
        logic signed [COORD_W-1:0]    world_x;
        logic signed [COORD_W-1:0]    world_z;
        logic [INDEX_W-1:0]           grid_col;
        logic [INDEX_W-1:0]           grid_row;
        logic signed [HEIGHT_W-1:0]   height_in;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic signed [HEIGHT_W-1:0]   height_out;
        logic                         in_range;
        logic signed [HEIGHT_W-1:0]   min_height;
        logic signed [HEIGHT_W-1:0]   max_height;
    } out_item_t;

    // Phase controls for the cell locator.
    typedef struct packed {
        logic load;
        logic mul_x;
        logic mul_z;
        logic check;
    } loc_ctl_t;

    // Located cell of a query: corner indexes and blend fractions.
    typedef struct packed {
        logic               ok;
        logic [INDEX_W-1:0] cx;
        logic [INDEX_W-1:0] cz;
        logic [FRAC_W-1:0]  fx;
        logic [FRAC_W-1:0]  fz;
    } cell_t;

    // Controls for the corner blend accumulator.
    typedef struct packed {
        logic       clear;
        logic       issue;
        logic [1:0] corner;
    } blend_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/hbs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the height store. No dependencies.
`default_nettype none

module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/hbs_locate.sv
// Query cell locator: origin offset, reciprocal scaling and range check.
// Shares one multiplier between the X and Z axes. Depends on hbs_pkg.
`default_nettype none

module hbs_locate (
    input  wire logic                                 clk,
    input  wire hbs_pkg::loc_ctl_t                    ctl,
    input  wire logic signed [hbs_pkg::COORD_W-1:0]   world_x,
    input  wire logic signed [hbs_pkg::COORD_W-1:0]   world_z,
    input  wire logic signed [hbs_pkg::COORD_W-1:0]   origin_x,
    input  wire logic signed [hbs_pkg::COORD_W-1:0]   origin_z,
    input  wire logic [hbs_pkg::INV_W-1:0]            inv_cell_size,
    input  wire logic [hbs_pkg::DIM_W-1:0]            eff_w,
    input  wire logic [hbs_pkg::DIM_W-1:0]            eff_d,
    output hbs_pkg::cell_t                            loc_cell
);

    import hbs_pkg::*;

    localparam int LOC_W  = COORD_W + 1;
    localparam int PROD_W = LOC_W + INV_W + 1;

    logic signed [LOC_W-1:0]  lx_next;
    logic signed [LOC_W-1:0]  lz_next;
    logic signed [LOC_W-1:0]  lx_reg;
    logic signed [LOC_W-1:0]  lz_reg;
    logic signed [LOC_W-1:0]  mul_a;
    logic signed [INV_W:0]    mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] pz_reg;
    logic                     x_in;
    logic                     z_in;
    cell_t                    cell_next;
    cell_t                    cell_reg;

    // Offset from the grid origin; the 33-bit difference cannot overflow.
    assign lx_next = {world_x[COORD_W-1], world_x} - {origin_x[COORD_W-1], origin_x};
    assign lz_next = {world_z[COORD_W-1], world_z} - {origin_z[COORD_W-1], origin_z};

    // One shared signed multiplier, X axis first, then Z.
    assign mul_a = ctl.mul_z ? lz_reg : lx_reg;
    assign mul_b = {1'b0, inv_cell_size};
    assign mul_p = mul_a * mul_b;

    // The cell index is the product above 24 fraction bits; the far corner
    // must stay below the effective size, so the index must be below size-1.
    assign x_in = (px_reg[PROD_W-2:33] == '0) && (px_reg[32:24] < (eff_w - 9'd1));
    assign z_in = (pz_reg[PROD_W-2:33] == '0) && (pz_reg[32:24] < (eff_d - 9'd1));

    always_comb
    begin
        cell_next.ok = (eff_w >= 9'd2) && (eff_d >= 9'd2)
                     && !px_reg[PROD_W-1] && !pz_reg[PROD_W-1] && x_in && z_in;
        cell_next.cx = px_reg[31:24];
        cell_next.cz = pz_reg[31:24];
        cell_next.fx = px_reg[23:16];
        cell_next.fz = pz_reg[23:16];
    end

    // Datapath registers, loaded by phase.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            lx_reg <= lx_next;
            lz_reg <= lz_next;
        end
        if (ctl.mul_x)
        begin
            px_reg <= mul_p;
        end
        if (ctl.mul_z)
        begin
            pz_reg <= mul_p;
        end
        if (ctl.check)
        begin
            cell_reg <= cell_next;
        end
    end

    assign loc_cell = cell_reg;

endmodule

`default_nettype wire

FILE: rtl/hbs_blend.sv
// Bilinear blend accumulator: weights each corner height as it leaves the
// store and sums the four terms. Depends on hbs_pkg.
`default_nettype none

module hbs_blend (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire hbs_pkg::blend_ctl_t                  ctl,
    input  wire logic [hbs_pkg::FRAC_W-1:0]           fx,
    input  wire logic [hbs_pkg::FRAC_W-1:0]           fz,
    input  wire logic signed [hbs_pkg::HEIGHT_W-1:0]  rdata,
    output logic signed [hbs_pkg::HEIGHT_W-1:0]       height
);

    import hbs_pkg::*;

    localparam int WT_W  = 2 * FRAC_W + 1;
    localparam int ACC_W = HEIGHT_W + WT_W + 1;

    logic [FRAC_W:0]         wx;
    logic [FRAC_W:0]         wz;
    logic [2*FRAC_W+1:0]     weight_full;
    logic [WT_W-1:0]         w_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    v1_reg;
    logic                    v2_reg;

    // Corner weight is the product of the X and Z fractions it takes.
    assign wx = ctl.corner[0] ? {1'b0, fx} : (9'd256 - {1'b0, fx});
    assign wz = ctl.corner[1] ? {1'b0, fz} : (9'd256 - {1'b0, fz});
    assign weight_full = wx * wz;

    // Height times weight, once the store read data is out.
    assign prod_next = rdata * $signed({1'b0, w_reg});

    // Stage valids track a corner from read issue to accumulation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
        end
    end

    // Weight, product and running sum.
    always_ff @(posedge clk)
    begin
        w_reg <= weight_full[WT_W-1:0];
        if (v1_reg)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.clear)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    // Arithmetic shift right by 16, kept to the height width.
    assign height = acc_reg[HEIGHT_W+15:16];

endmodule

`default_nettype wire

FILE: rtl/heightmap_bilinear_sampler.sv
// Height map store with bilinear height queries; top level and sequencer.
// A write beat passes through the write state and then shows its result.
// A query passes the X multiply, Z multiply, check and decide states and,
// when it falls outside the grid, answers from the decide state; else four
// corner reads through the store's single read port, a drain and a finish follow.
// busy drops in the cycle the result strobe is shown. Reset restores the
// registers and extremes; the store is not cleared and holds garbage.
`default_nettype none

module heightmap_bilinear_sampler #(
    parameter int COLS_MAX = 256,
    parameter int ROWS_MAX = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire hbs_pkg::in_item_t                   item,
    output logic                                     done,
    output hbs_pkg::out_item_t                       result,
    input  wire logic                                cfg_we,
    input  wire logic [hbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [hbs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import hbs_pkg::*;

    localparam int DEPTH = COLS_MAX * ROWS_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [DIM_W:0] COLS_CAP = (COLS_MAX > 511) ? 10'd511 : 10'(COLS_MAX);
    localparam logic [DIM_W:0] ROWS_CAP = (ROWS_MAX > 511) ? 10'd511 : 10'(ROWS_MAX);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_WRITE  = 9'b000000010,
        S_MULX   = 9'b000000100,
        S_MULZ   = 9'b000001000,
        S_CHECK  = 9'b000010000,
        S_DECIDE = 9'b000100000,
        S_READ   = 9'b001000000,
        S_DRAIN  = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [1:0]                  cnt_reg;
    logic [1:0]                  cnt_next;
    logic                        done_reg;
    logic                        done_next;
    out_item_t                   result_reg;
    out_item_t                   result_next;
    in_item_t                    item_reg;
    logic signed [HEIGHT_W-1:0]  min_reg;
    logic signed [HEIGHT_W-1:0]  min_next;
    logic signed [HEIGHT_W-1:0]  max_reg;
    logic signed [HEIGHT_W-1:0]  max_next;

    logic signed [COORD_W-1:0]   origin_x_reg;
    logic signed [COORD_W-1:0]   origin_z_reg;
    logic [INV_W-1:0]            inv_reg;
    logic [DIM_W-1:0]            grid_width_reg;
    logic [DIM_W-1:0]            grid_depth_reg;
    logic [DIM_W-1:0]            eff_w;
    logic [DIM_W-1:0]            eff_d;

    logic                        accept;
    logic                        wr_ok;
    loc_ctl_t                    loc_ctl;
    cell_t                       loc_cell;
    blend_ctl_t                  blend_ctl;
    logic [INDEX_W-1:0]          rd_col;
    logic [INDEX_W-1:0]          rd_row;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [AW-1:0]               ram_raddr;
    logic [HEIGHT_W-1:0]         ram_rdata;
    logic signed [HEIGHT_W-1:0]  blend_height;

    // Store address of a column and row.
    function automatic logic [AW-1:0] addr_of(input logic [INDEX_W-1:0] col,
                                              input logic [INDEX_W-1:0] row);
        logic [AW-1:0] a;
        a = AW'(row) * AW'(COLS_MAX) + AW'(col);
        return a;
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_z_reg   <= '0;
            inv_reg        <= INV_RESET;
            grid_width_reg <= '0;
            grid_depth_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:   origin_x_reg   <= cfg_data;
                CFG_ORIGIN_Z:   origin_z_reg   <= cfg_data;
                CFG_INV_CELL:   inv_reg        <= cfg_data[INV_W-1:0];
                CFG_GRID_WIDTH: grid_width_reg <= cfg_data[DIM_W-1:0];
                CFG_GRID_DEPTH: grid_depth_reg <= cfg_data[DIM_W-1:0];
                default:        ;
            endcase
        end
    end

    // Grid size clamped to the store dimensions.
    assign eff_w = ({1'b0, grid_width_reg} > COLS_CAP) ? COLS_CAP[DIM_W-1:0] : grid_width_reg;
    assign eff_d = ({1'b0, grid_depth_reg} > ROWS_CAP) ? ROWS_CAP[DIM_W-1:0] : grid_depth_reg;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // A write lands only inside the used grid.
    assign wr_ok = ({1'b0, item_reg.grid_col} < eff_w) && ({1'b0, item_reg.grid_row} < eff_d);

    // Running extremes widen on each landed write.
    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if ((state_reg == S_WRITE) && wr_ok)
        begin
            if (item_reg.height_in < min_reg)
            begin
                min_next = item_reg.height_in;
            end
            if (item_reg.height_in > max_reg)
            begin
                max_next = item_reg.height_in;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.func == FUNC_WRITE) ? S_WRITE : S_MULX;
                end
            end
            S_WRITE:
            begin
                done_next              = 1'b1;
                result_next.height_out = '0;
                result_next.in_range   = wr_ok;
                result_next.min_height = min_next;
                result_next.max_height = max_next;
                state_next             = S_IDLE;
            end
            S_MULX:   state_next = S_MULZ;
            S_MULZ:   state_next = S_CHECK;
            S_CHECK:  state_next = S_DECIDE;
            S_DECIDE:
            begin
                cnt_next = '0;
                if (loc_cell.ok)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    done_next              = 1'b1;
                    result_next.height_out = '0;
                    result_next.in_range   = 1'b0;
                    result_next.min_height = min_reg;
                    result_next.max_height = max_reg;
                    state_next             = S_IDLE;
                end
            end
            S_READ:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd1)
                begin
                    cnt_next   = '0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                done_next              = 1'b1;
                result_next.height_out = blend_height;
                result_next.in_range   = 1'b1;
                result_next.min_height = min_reg;
                result_next.max_height = max_reg;
                state_next             = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Control state and extremes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            min_reg   <= LOWEST_INIT;
            max_reg   <= HIGHEST_INIT;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    // Accepted beat and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Locator phases.
    always_comb
    begin
        loc_ctl.load  = accept && (item.func == FUNC_QUERY);
        loc_ctl.mul_x = (state_reg == S_MULX);
        loc_ctl.mul_z = (state_reg == S_MULZ);
        loc_ctl.check = (state_reg == S_CHECK);
    end

    hbs_locate u_locate (
        .clk           (clk),
        .ctl           (loc_ctl),
        .world_x       (item.world_x),
        .world_z       (item.world_z),
        .origin_x      (origin_x_reg),
        .origin_z      (origin_z_reg),
        .inv_cell_size (inv_reg),
        .eff_w         (eff_w),
        .eff_d         (eff_d),
        .loc_cell      (loc_cell)
    );

    // Corner reads: bit 0 of the count steps X, bit 1 steps Z.
    assign rd_col    = loc_cell.cx + {{(INDEX_W-1){1'b0}}, cnt_reg[0]};
    assign rd_row    = loc_cell.cz + {{(INDEX_W-1){1'b0}}, cnt_reg[1]};
    assign ram_raddr = addr_of(rd_col, rd_row);
    assign ram_we    = (state_reg == S_WRITE) && wr_ok;
    assign ram_waddr = addr_of(item_reg.grid_col, item_reg.grid_row);

    hbs_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_reg.height_in),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        blend_ctl.clear  = (state_reg == S_DECIDE);
        blend_ctl.issue  = (state_reg == S_READ);
        blend_ctl.corner = cnt_reg;
    end

    hbs_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (blend_ctl),
        .fx     (loc_cell.fx),
        .fz     (loc_cell.fz),
        .rdata  (ram_rdata),
        .height (blend_height)
    );

    // A result beat only appears once the sequencer is free again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat shown while busy");

    // A write beat always answers once its write state has passed.
    a_write_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.func == FUNC_WRITE)) |=> ##1 done)
        else $error("write beat result missing");

    // A query outside the grid answers zero with the range flag clear.
    a_query_miss: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DECIDE) && !loc_cell.ok)
            |=> (done && !result.in_range && (result.height_out == '0)))
        else $error("query miss result wrong");

    // After a landed write the extremes are ordered.
    a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.in_range && $past(state_reg == S_WRITE))
            |-> (result.min_height <= result.max_height))
        else $error("extremes out of order after write");

endmodule

`default_nettype wire

FILE: test/height_grid_model_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the height map bilinear sampler: a bit-exact predictor of the
// grid store, the running extremes and the bilinear query. Depends on hbs_pkg.

package height_grid_model_pkg;

    import hbs_pkg::*;

    localparam int GRID_COLS = 256;
    localparam int GRID_ROWS = 256;

    class height_grid_scoreboard;

        // Register copies, as written through the configuration port.
        logic signed [COORD_W-1:0]  org_x;
        logic signed [COORD_W-1:0]  org_z;
        logic [INV_W-1:0]           inv_cell;
        logic [DIM_W-1:0]           cols_reg;
        logic [DIM_W-1:0]           rows_reg;

        // Store contents, which entries hold data, and the running extremes.
        logic signed [HEIGHT_W-1:0] heights [GRID_COLS*GRID_ROWS];
        bit                         written [GRID_COLS*GRID_ROWS];
        logic signed [HEIGHT_W-1:0] lowest;
        logic signed [HEIGHT_W-1:0] highest;

        out_item_t                  expected_results [$];
        int                         errors;

        function new();
            org_x    = '0;
            org_z    = '0;
            inv_cell = INV_RESET;
            cols_reg = '0;
            rows_reg = '0;
            lowest   = LOWEST_INIT;
            highest  = HIGHEST_INIT;
            errors   = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ORIGIN_X:   org_x = data;
                CFG_ORIGIN_Z:   org_z = data;
                CFG_INV_CELL:   inv_cell = data[INV_W-1:0];
                CFG_GRID_WIDTH: cols_reg = data[DIM_W-1:0];
                CFG_GRID_DEPTH: rows_reg = data[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Grid sizes above the store's size act as the store's size.
        function int eff_cols();
            return (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
        endfunction

        function int eff_rows();
            return (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
        endfunction

        function bit is_written(logic [INDEX_W-1:0] col, logic [INDEX_W-1:0] row);
            return written[{row, col}];
        endfunction

        // Maps a world point to its cell and blend weights; returns 0 when the
        // grid is too small or the cell's far corner lies outside it.
        function bit locate(logic signed [COORD_W-1:0] wx, logic signed [COORD_W-1:0] wz,
                            output logic [INDEX_W-1:0] cx, output logic [INDEX_W-1:0] cz,
                            output logic [FRAC_W-1:0] fx, output logic [FRAC_W-1:0] fz);
            longint px;
            longint pz;
            cx = '0;
            cz = '0;
            fx = '0;
            fz = '0;
            if (eff_cols() < 2 || eff_rows() < 2)
                return 0;
            px = (longint'(wx) - longint'(org_x)) * longint'(inv_cell);
            pz = (longint'(wz) - longint'(org_z)) * longint'(inv_cell);
            if (px < 0 || pz < 0)
                return 0;
            if ((px >>> 24) + 1 >= eff_cols() || (pz >>> 24) + 1 >= eff_rows())
                return 0;
            cx = 8'(px >>> 24);
            cz = 8'(pz >>> 24);
            fx = 8'(px >>> 16);
            fz = 8'(pz >>> 16);
            return 1;
        endfunction

        // Predicts the result of an accepted input beat and queues it.
        function void note_item(in_item_t it);
            out_item_t   want;
            logic [INDEX_W-1:0] cx;
            logic [INDEX_W-1:0] cz;
            logic [FRAC_W-1:0]  fx;
            logic [FRAC_W-1:0]  fz;
            logic [INDEX_W-1:0] cx1;
            logic [INDEX_W-1:0] cz1;
            longint h1;
            longint h2;
            longint h;
            want = '0;
            if (it.func == FUNC_WRITE)
            begin
                if (it.grid_col < eff_cols() && it.grid_row < eff_rows())
                begin
                    heights[{it.grid_row, it.grid_col}] = it.height_in;
                    written[{it.grid_row, it.grid_col}] = 1'b1;
                    if (it.height_in < lowest)
                        lowest = it.height_in;
                    if (it.height_in > highest)
                        highest = it.height_in;
                    want.in_range = 1'b1;
                end
            end
            else if (locate(it.world_x, it.world_z, cx, cz, fx, fz))
            begin
                // Blend along X on both rows, then along Z, then floor by 2^16.
                cx1 = cx + 8'd1;
                cz1 = cz + 8'd1;
                h1 = longint'(heights[{cz, cx}]) * (256 - longint'(fx))
                   + longint'(heights[{cz, cx1}]) * longint'(fx);
                h2 = longint'(heights[{cz1, cx}]) * (256 - longint'(fx))
                   + longint'(heights[{cz1, cx1}]) * longint'(fx);
                h = h1 * (256 - longint'(fz)) + h2 * longint'(fz);
                want.height_out = 16'(h >>> 16);
                want.in_range   = 1'b1;
            end
            want.min_height = lowest;
            want.max_height = highest;
            expected_results = {expected_results, want};
        endfunction

        // Compares one result beat with the oldest prediction.
        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: height_out %0d in_range %0b",
                       got.height_out, got.in_range);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.height_out !== want.height_out)
            begin
                $error("height_out: expected %0d, got %0d", want.height_out, got.height_out);
                errors++;
            end
            if (got.in_range !== want.in_range)
            begin
                $error("in_range: expected %0b, got %0b", want.in_range, got.in_range);
                errors++;
            end
            if (got.min_height !== want.min_height)
            begin
                $error("min_height: expected %0d, got %0d", want.min_height, got.min_height);
                errors++;
            end
            if (got.max_height !== want.max_height)
            begin
                $error("max_height: expected %0d, got %0d", want.max_height, got.max_height);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

    endclass

endpackage

FILE: test/tb_heightmap_bilinear_sampler.sv
`timescale 1ns / 1ps
// Testbench for heightmap_bilinear_sampler: directed and random write and
// query beats with random gaps and register phases. Depends on hbs_pkg and
// height_grid_model_pkg.

module tb_heightmap_bilinear_sampler;

    import hbs_pkg::*;
    import height_grid_model_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_LIMIT  = 500;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    in_item_t               item_beat = '0;
    logic                   done;
    out_item_t              result;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    height_grid_scoreboard  sb = new();
    int                     items_sent = 0;
    int                     quiet_cycles = 0;
    bit                     steady = 1'b0;

    heightmap_bilinear_sampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item_beat),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Every strobed result beat is checked against the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && done)
            sb.check_result(result);
    end

    // Watchdog: ends the run when no beat moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_heightmap_bilinear_sampler: FAIL");
                $finish;
            end
        end
    end

    function automatic in_item_t make_write(logic [INDEX_W-1:0] col, logic [INDEX_W-1:0] row,
                                            logic signed [HEIGHT_W-1:0] h);
        in_item_t it;
        it.func      = FUNC_WRITE;
        it.world_x   = $urandom;
        it.world_z   = $urandom;
        it.grid_col  = col;
        it.grid_row  = row;
        it.height_in = h;
        return it;
    endfunction

    function automatic in_item_t make_query(logic signed [COORD_W-1:0] wx,
                                            logic signed [COORD_W-1:0] wz);
        in_item_t it;
        it.func      = FUNC_QUERY;
        it.world_x   = wx;
        it.world_z   = wz;
        it.grid_col  = 8'($urandom);
        it.grid_row  = 8'($urandom);
        it.height_in = 16'($urandom);
        return it;
    endfunction

    // World coordinate that lands on a chosen cell of one axis, mostly inside.
    function automatic logic [COORD_W-1:0] aim_coord(logic signed [COORD_W-1:0] org, int span);
        int     top_cell;
        longint target;
        longint offset;
        top_cell = ($urandom_range(0, 7) == 0) ? span - 1 : span - 2;
        if (top_cell < 0)
            top_cell = 0;
        target = (longint'($urandom_range(0, top_cell)) << 24)
               | longint'($urandom_range(0, 24'hFF_FFFF));
        if ($urandom_range(0, 11) == 0)
            target = -target - 1;
        if (sb.inv_cell == '0)
            offset = longint'($urandom_range(0, 16'hFFFF));
        else
            offset = target / longint'(sb.inv_cell);
        return 32'(longint'(org) + offset);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 9'($urandom_range(2, 8));
        else if (r < 14)
            return 9'($urandom_range(0, 1));
        else if (r < 17)
            return 9'($urandom_range(9, 64));
        else if (r < 19)
            return 9'($urandom_range(256, 511));
        return 9'($urandom_range(0, 511));
    endfunction

    function automatic logic [COORD_W-1:0] pick_origin();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return '0;
        else if (r < 7)
            return 32'($urandom_range(0, 32'h20_0000)) - 32'h10_0000;
        else if (r < 9)
            return $urandom;
        return (r[0]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    // Drives one input beat after a random gap and waits for its acceptance.
    task automatic send_item(in_item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        item_beat <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(it);
        items_sent++;
    endtask

    // A query whose cell lies inside the grid first gets its unwritten
    // corners written, so that it never reads an empty store entry.
    task automatic send_query(logic signed [COORD_W-1:0] wx, logic signed [COORD_W-1:0] wz);
        logic [INDEX_W-1:0] cx;
        logic [INDEX_W-1:0] cz;
        logic [FRAC_W-1:0]  fx;
        logic [FRAC_W-1:0]  fz;
        logic [INDEX_W-1:0] col;
        logic [INDEX_W-1:0] row;
        if (sb.locate(wx, wz, cx, cz, fx, fz)) begin
            for (int k = 0; k < 4; k++) begin
                col = cx + 8'(k % 2);
                row = cz + 8'(k / 2);
                if (!sb.is_written(col, row))
                    send_item(make_write(col, row, 16'($urandom)));
            end
        end
        send_item(make_query(wx, wz));
    endtask

    // Lets every pending result arrive so that the block is idle.
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all five registers; unused upper data bits carry random junk.
    task automatic load_config(logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oz,
                               logic [INV_W-1:0] inv, logic [DIM_W-1:0] w,
                               logic [DIM_W-1:0] d);
        logic [CFG_DATA_W-1:0] regs [5];
        cfg_reg_t              idx;
        regs[0] = ox;
        regs[1] = oz;
        regs[2] = {8'($urandom), inv};
        regs[3] = {23'($urandom), w};
        regs[4] = {23'($urandom), d};
        for (int i = 0; i < 5; i++) begin
            idx = cfg_reg_t'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= regs[i];
            @(posedge clk);
            sb.set_reg(idx, regs[i]);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        int                first_random;
        int                phase_len;
        int                pick;
        logic [INV_W-1:0]  inv;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a zero-sized grid rejects queries and writes.
        send_query(32'sd0, 32'sd0);
        send_item(make_write(8'd0, 8'd0, 16'sd100));

        // Cells of 256 world units on a 4x3 grid: corners, weight extremes, edges.
        settle();
        load_config(32'd0, 32'd0, INV_RESET, 9'd4, 9'd3);
        send_item(make_write(8'd0, 8'd0, 16'sh8000));
        send_item(make_write(8'd1, 8'd0, 16'sh7FFF));
        send_item(make_write(8'd0, 8'd1, 16'sd0));
        send_item(make_write(8'd1, 8'd1, -16'sd1));
        send_query(32'sd0, 32'sd0);
        send_query(32'sd255, 32'sd255);
        send_query(32'sd128, 32'sd0);
        send_query(-32'sd1, 32'sd0);
        send_query(32'sd768, 32'sd0);
        send_query(32'sd767, 32'sd511);
        send_query(32'sd0, 32'sd512);
        send_query(32'sh7FFF_FFFF, 32'sd0);
        send_query(32'sh8000_0000, 32'sh8000_0000);
        send_item(make_write(8'd4, 8'd0, 16'sd5));
        send_item(make_write(8'd0, 8'd3, 16'sd5));
        send_item(make_write(8'd255, 8'd255, 16'sd5));

        // A zero reciprocal maps every point to cell 0,0 with zero fractions.
        settle();
        load_config(32'd0, 32'd0, 24'd0, 9'd4, 9'd3);
        send_query(32'sd12345, -32'sd999);
        send_query(32'sh8000_0000, 32'sh7FFF_FFFF);

        // Extreme origins and reciprocal; oversized grid registers clamp.
        settle();
        load_config(32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF, 9'd511, 9'd300);
        send_item(make_write(8'd255, 8'd255, 16'sd7));
        send_query(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);

        // Grids below 2x2 reject every query; the 1x5 grid still takes writes.
        settle();
        load_config(32'd0, 32'd0, INV_RESET, 9'd1, 9'd5);
        send_item(make_write(8'd0, 8'd4, 16'sd3));
        send_query(32'sd100, 32'sd100);
        settle();
        load_config(32'd0, 32'd0, INV_RESET, 9'd6, 9'd0);
        send_query(32'sd100, 32'sd100);
        send_item(make_write(8'd0, 8'd0, 16'sd3));

        // Random phases, each under fresh register settings.
        first_random = items_sent;
        while (items_sent - first_random < RANDOM_ITEMS) begin
            settle();
            pick = $urandom_range(0, 19);
            if (pick < 6)
                inv = INV_RESET;
            else if (pick < 14)
                inv = 24'($urandom_range(1, 24'hFF_FFFF));
            else if (pick < 18)
                inv = 24'($urandom_range(24'h00_1000, 24'h04_0000));
            else if (pick < 19)
                inv = '0;
            else
                inv = 24'hFF_FFFF;
            load_config(pick_origin(), pick_origin(), inv, pick_dim(), pick_dim());
            steady    = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(60, 140);
            for (int k = 0; k < phase_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    send_query(aim_coord(sb.org_x, sb.eff_cols()),
                               aim_coord(sb.org_z, sb.eff_rows()));
                else if (pick < 72)
                    send_query($urandom, $urandom);
                else if (pick < 92 && sb.eff_cols() > 0 && sb.eff_rows() > 0)
                    send_item(make_write(8'($urandom_range(0, sb.eff_cols() - 1)),
                                         8'($urandom_range(0, sb.eff_rows() - 1)),
                                         16'($urandom)));
                else
                    send_item(make_write(8'($urandom), 8'($urandom), 16'($urandom)));
            end
        end

        // Drain, then allow a little slack for any stray result beat.
        settle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_heightmap_bilinear_sampler: PASS");
        else
            $display("tb_heightmap_bilinear_sampler: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/hbs_pkg.sv
rtl/hbs_ram.sv
rtl/hbs_locate.sv
rtl/hbs_blend.sv
rtl/heightmap_bilinear_sampler.sv
test/height_grid_model_pkg.sv
test/tb_heightmap_bilinear_sampler.sv
